@@ hdl/dlts_pkg.sv @@
// ----------------------------------------------------------------------------
// Delta-list task scheduler package
// Shared types, constants and the millisecond-to-tick conversion.
// ----------------------------------------------------------------------------
package dlts_pkg;

  localparam int MaxTasksDefault = 16;
  localparam int MaxResults      = 16;
  localparam int DeltaW          = 29;
  localparam int TickMs          = 10;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_DISPATCH = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_ADDED = 3'd0,
    KIND_FULL  = 3'd1,
    KIND_TICK  = 3'd2,
    KIND_DUE   = 3'd3,
    KIND_NONE  = 3'd4
  } kind_t;

  // One queued command word between the front and back parts.
  typedef struct packed {
    req_t        req;
    logic [7:0]  handle;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
  } cmd_t;

  // Quotient by ten through a reciprocal multiply and one correction.
  function automatic logic [31:0] div10(input logic [31:0] v);
    logic [63:0] prod;
    logic [31:0] q;
    logic [35:0] rem;
    begin
      prod = {32'd0, v} * 64'hCCCC_CCCD;
      q    = {3'd0, prod[63:35]};
      rem  = {4'd0, v} - ({4'd0, q} * 36'd10);
      if (rem >= 36'd10) q = q + 32'd1;
      div10 = q;
    end
  endfunction

endpackage

@@ hdl/dlts_front.sv @@
// ----------------------------------------------------------------------------
// Delta-list task scheduler front part
// Accepts command words and holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
module dlts_front import dlts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  req_type,
  input  logic [7:0]  task_handle,
  input  logic [31:0] delay_ms,
  input  logic [31:0] period_ms,
  output logic        busy,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_take
);

  localparam int Depth = 2;

  cmd_t       queue [Depth];
  logic [0:0] wr_ptr;
  logic [0:0] rd_ptr;
  logic [1:0] count;
  logic       push;

  // Unknown request words are dropped here; they cause no result.
  assign busy      = (count == 2'(Depth));
  assign push      = start && !busy && (req_t'(req_type) != REQ_NONE);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{req_t'(req_type), task_handle, delay_ms, period_ms};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (cmd_take) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(push) - 2'(cmd_take);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd_take |-> cmd_valid)
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst) count <= 2'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (push && !cmd_take) |=> count == $past(count) + 2'd1)
    else $error("queue count lost a push");

endmodule

@@ hdl/dlts_back.sv @@
// ----------------------------------------------------------------------------
// Delta-list task scheduler back part
// Sequencer over the slot memories: insertion walk, tick and dispatch.
// ----------------------------------------------------------------------------
module dlts_back import dlts_pkg::*; #(
  parameter int MAX_TASKS = MaxTasksDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  output logic       strobe,
  output logic [2:0] result_kind,
  output logic [7:0] due_handle,
  output logic       last
);

  localparam int SW = $clog2(MAX_TASKS + 1);
  localparam int IW = $clog2(MAX_TASKS);
  localparam logic [SW-1:0] Nil = SW'(MAX_TASKS);
  localparam int CW = $clog2(MaxResults + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CONV, S_FIND, S_WALK, S_LINK, S_TICK, S_DCHK, S_DPOP, S_DRE
  } state_t;

  logic [MAX_TASKS-1:0] slot_used;
  logic [7:0]           slot_handle [MAX_TASKS];
  logic [DeltaW-1:0]    slot_delta  [MAX_TASKS];
  logic [31:0]          slot_period [MAX_TASKS];
  logic [SW-1:0]        slot_next   [MAX_TASKS];

  state_t        state;
  logic [SW-1:0] head;
  logic [31:0]   ticks;
  logic [7:0]    new_handle;
  logic [31:0]   new_period;
  logic [IW-1:0] new_slot;
  logic [SW-1:0] prev;
  logic [SW-1:0] cur;
  logic [SW-1:0] guard;
  logic          redo;
  logic [CW-1:0] n_due;

  logic [IW-1:0] free_idx;
  logic          free_any;
  logic [IW-1:0] cur_idx;
  logic [IW-1:0] head_idx;
  logic [31:0]   cur_delta;
  logic [31:0]   per_ticks;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign cur_idx   = cur[IW-1:0];
  assign head_idx  = head[IW-1:0];
  assign cur_delta = {3'd0, slot_delta[cur_idx]};
  assign per_ticks = div10(new_period);
  assign cmd_take  = (state == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      slot_used   <= '0;
      head        <= Nil;
      result_kind <= KIND_ADDED;
      due_handle  <= '0;
      last        <= 1'b0;
      redo        <= 1'b0;
      n_due       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            new_handle <= cmd.handle;
            new_period <= cmd.period_ms;
            ticks      <= cmd.delay_ms;
            redo       <= 1'b0;
            n_due      <= '0;
            case (cmd.req)
              REQ_ADD:      state <= S_CONV;
              REQ_TICK:     state <= S_TICK;
              REQ_DISPATCH: state <= S_DCHK;
              default:      state <= S_IDLE;
            endcase
          end
        end
        S_CONV: begin
          ticks <= div10(ticks);
          state <= S_FIND;
        end
        S_FIND: begin
          if (!free_any) begin
            // Only an add can miss; re-insertion always finds the slot just freed.
            strobe      <= 1'b1;
            result_kind <= KIND_FULL;
            due_handle  <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            slot_used[free_idx]   <= 1'b1;
            slot_handle[free_idx] <= new_handle;
            slot_period[free_idx] <= new_period;
            new_slot <= free_idx;
            prev     <= Nil;
            cur      <= head;
            guard    <= '0;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          // One list entry per cycle; equal deltas are passed over.
          if (cur < Nil && guard < Nil && ticks >= cur_delta) begin
            ticks <= ticks - cur_delta;
            prev  <= cur;
            cur   <= (slot_next[cur_idx] > Nil) ? Nil : slot_next[cur_idx];
            guard <= guard + 1'b1;
          end else begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          slot_delta[new_slot] <= ticks[DeltaW-1:0];
          slot_next[new_slot]  <= cur;
          if (prev == Nil) head <= SW'(new_slot);
          else slot_next[prev[IW-1:0]] <= SW'(new_slot);
          if (cur < Nil) slot_delta[cur_idx] <= slot_delta[cur_idx] - ticks[DeltaW-1:0];
          if (redo) begin
            state <= S_DCHK;
          end else begin
            strobe      <= 1'b1;
            result_kind <= KIND_ADDED;
            due_handle  <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_TICK: begin
          if (head < Nil && slot_delta[head_idx] != '0) begin
            slot_delta[head_idx] <= slot_delta[head_idx] - 1'b1;
          end
          strobe      <= 1'b1;
          result_kind <= KIND_TICK;
          due_handle  <= '0;
          last        <= 1'b1;
          state       <= S_IDLE;
        end
        S_DCHK: begin
          if (n_due < CW'(MaxResults) && head < Nil && slot_delta[head_idx] == '0) begin
            state <= S_DPOP;
          end else begin
            // The previous due word is held back until its last flag is known.
            strobe      <= 1'b1;
            last        <= 1'b1;
            if (n_due == '0) begin
              result_kind <= KIND_NONE;
              due_handle  <= '0;
            end else begin
              result_kind <= KIND_DUE;
              due_handle  <= new_handle;
            end
            state <= S_IDLE;
          end
        end
        S_DPOP: begin
          if (n_due != '0) begin
            strobe      <= 1'b1;
            result_kind <= KIND_DUE;
            due_handle  <= new_handle;
            last        <= 1'b0;
          end
          new_handle      <= slot_handle[head_idx];
          new_period      <= slot_period[head_idx];
          slot_used[head_idx] <= 1'b0;
          head  <= (slot_next[head_idx] > Nil) ? Nil : slot_next[head_idx];
          n_due <= n_due + 1'b1;
          state <= S_DRE;
        end
        S_DRE: begin
          if (new_period != '0) begin
            ticks <= (per_ticks == '0) ? 32'd1 : per_ticks;
            redo  <= 1'b1;
            state <= S_FIND;
          end else begin
            state <= S_DCHK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (strobe && result_kind == KIND_NONE) |-> last)
    else $error("nothing due must be a single final word");
  assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> !strobe)
    else $error("result word in the cycle after taking a command");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (guard <= Nil))
    else $error("list walk ran past the slot count");

endmodule

@@ hdl/delta_list_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// Delta-list task scheduler
// Timed tasks kept in a delta-sorted slot list; add, tick and dispatch.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Ports
// request   in         start, busy        req_type task_handle delay_ms period_ms
// result    out        strobe (no stall)  result_kind due_handle last
//
// A tick lowers the head entry's delta if it is not zero. An add converts the delay
// to ticks, then its insertion walk passes one list entry per cycle (up to MAX_TASKS);
// an add is rejected when no slot is free. A dispatch pops each due task and
// re-inserts each periodic one through the same insertion walk.
// rst is synchronous; it empties the list and the two-word request queue.
// busy is high only while the request queue is full; results cannot be held.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler import dlts_pkg::*; #(
  parameter int MAX_TASKS = MaxTasksDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  task_handle,
  input  logic [31:0] delay_ms,
  input  logic [31:0] period_ms,
  output logic        strobe,
  output logic [2:0]  result_kind,
  output logic [7:0]  due_handle,
  output logic        last
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  dlts_front u_front (
    .clk, .rst, .start, .req_type, .task_handle, .delay_ms, .period_ms,
    .busy, .cmd_valid, .cmd, .cmd_take
  );

  dlts_back #(.MAX_TASKS(MAX_TASKS)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take,
    .strobe, .result_kind, .due_handle, .last
  );

endmodule
